>>> rtl/bsfic_pkg.sv
// shared types and constants for the buck state feedback integral controller
// no dependencies; imported by bsfic_shift_mac and the top level
`timescale 1ns / 1ps

package bsfic_pkg;

    localparam int GAIN_W  = 32;
    localparam int ACC_W   = 80;
    localparam int INTEG_W = 48;
    localparam int ERR_W   = 17;
    localparam int CNT_W   = 6;

    // register indexes on the configuration port
    localparam logic [1:0] REG_GAIN_CUR = 2'd0;
    localparam logic [1:0] REG_GAIN_VLT = 2'd1;
    localparam logic [1:0] REG_GAIN_INT = 2'd2;
    localparam logic [1:0] REG_PERIOD   = 2'd3;

    localparam logic [31:0] GAIN_CUR_RST = 32'h0000_0529;
    localparam logic [31:0] GAIN_VLT_RST = 32'hFFFF_EBDC;
    localparam logic [31:0] GAIN_INT_RST = 32'hFFFB_5E44;
    localparam logic [31:0] PERIOD_RST   = 32'h0000_A7C6;

    // request kinds
    localparam logic [1:0] REQ_RUN    = 2'd0;
    localparam logic [1:0] REQ_PRESET = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    typedef struct packed {
        logic               load;
        logic               clr;
        logic               step;
        logic               neg_last;
        logic [GAIN_W-1:0]  mpr;
        logic [ACC_W-1:0]   mcd;
    } t_mac_cmd;

endpackage

>>> rtl/bsfic_shift_mac.sv
// serial-parallel multiply accumulate: one multiplier bit per cycle while step is set, lsb first
// depends on bsfic_pkg
`timescale 1ns / 1ps

module bsfic_shift_mac
    import bsfic_pkg::*;
(
    input  logic             i_clk,
    input  t_mac_cmd         i_cmd,
    output logic [ACC_W-1:0] o_acc
);

    logic [GAIN_W-1:0] r_mpr;
    logic [ACC_W-1:0]  r_mcd;
    logic [ACC_W-1:0]  r_acc;
    logic [ACC_W-1:0]  addend;
    logic [ACC_W-1:0]  n_acc;

    assign addend = r_mpr[0] ? r_mcd : '0;
    // the top bit of a signed multiplier carries negative weight
    assign n_acc  = i_cmd.neg_last ? (r_acc - addend) : (r_acc + addend);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mpr <= i_cmd.mpr;
            r_mcd <= i_cmd.mcd;
        end else if (i_cmd.step) begin
            r_mpr <= r_mpr >> 1;
            r_mcd <= r_mcd << 1;
        end
        if (i_cmd.load && i_cmd.clr) begin
            r_acc <= '0;
        end else if (i_cmd.step) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

>>> rtl/buck_state_feedback_integral_controller_core.sv
// buck converter duty controller, state feedback with trapezoidal integral action
// depends on bsfic_pkg and bsfic_shift_mac
`timescale 1ns / 1ps

// One request is worked on at a time; the input is ready again as soon as the
// result has moved to the output register. All products go through one
// bit-serial multiply accumulate unit and both divisions through one
// restoring divider. A preset whose quotient would overflow the integrator
// skips the second division; a preset that would divide by zero, a clear and
// an unused request code go straight to the result.
// Gains and sample period are to be written through the APB port while the
// block is idle; the block itself does not enforce this.

module buck_state_feedback_integral_controller_core
    import bsfic_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // inductor_current, output_voltage, reference_voltage, dc_output_voltage,
    // input_voltage, zero pad
    input  logic [79:0] i_s_tdata,
    // req_type
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // duty, zero pad
    output logic [23:0] o_m_tdata,
    // clamped, fault
    output logic [1:0]  o_m_tuser,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_R_INC = 4'd1;
    localparam logic [3:0] ST_R_ACC = 4'd2;
    localparam logic [3:0] ST_R_KI  = 4'd3;
    localparam logic [3:0] ST_R_KV  = 4'd4;
    localparam logic [3:0] ST_R_KE  = 4'd5;
    localparam logic [3:0] ST_R_FIN = 4'd6;
    localparam logic [3:0] ST_P_RAT = 4'd7;
    localparam logic [3:0] ST_P_KI  = 4'd8;
    localparam logic [3:0] ST_P_KV  = 4'd9;
    localparam logic [3:0] ST_P_NUM = 4'd10;
    localparam logic [3:0] ST_P_CHK = 4'd11;
    localparam logic [3:0] ST_P_DIV = 4'd12;
    localparam logic [3:0] ST_P_FIN = 4'd13;
    localparam logic [3:0] ST_WB    = 4'd14;

    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(GAIN_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(46);

    logic [3:0]         r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [31:0]        r_gi, r_gv, r_ge, r_sp;
    logic [INTEG_W-1:0] r_ei, n_ei;
    logic [ERR_W-1:0]   r_prev, n_prev;
    logic [ERR_W-1:0]   r_ev, n_ev;
    logic [15:0]        r_cur, n_cur;
    logic [15:0]        r_vlt, n_vlt;
    logic               r_nsg, n_nsg;
    logic               r_neg, n_neg;
    logic [32:0]        r_rem, n_rem;
    logic [46:0]        r_dvd, n_dvd;
    logic [31:0]        r_dvs, n_dvs;
    logic [49:0]        r_num, n_num;
    logic [16:0]        r_res_duty, n_res_duty;
    logic               r_res_clp, n_res_clp;
    logic               r_res_flt, n_res_flt;
    logic               r_m_valid;
    logic [16:0]        r_m_duty;
    logic               r_m_clp;
    logic               r_m_flt;

    t_mac_cmd           mac_cmd;
    logic [ACC_W-1:0]   w_acc;

    logic               in_acc;
    logic               out_load;
    logic               cfg_wr;

    logic [1:0]         in_req;
    logic [15:0]        in_cur, in_vo, in_ref, in_vdc;
    logic [14:0]        in_vin;

    logic [32:0]        rem_sh;
    logic               dv_ge;
    logic [32:0]        rem_nx;

    assign in_req = i_s_tuser;
    assign in_cur = i_s_tdata[15:0];
    assign in_vo  = i_s_tdata[31:16];
    assign in_ref = i_s_tdata[47:32];
    assign in_vdc = i_s_tdata[63:48];
    assign in_vin = i_s_tdata[78:64];

    assign o_s_tready = (r_state == ST_IDLE);
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign out_load   = (r_state == ST_WB) && (!r_m_valid || i_m_tready);

    // restoring divider step
    assign rem_sh = {r_rem[31:0], r_dvd[46]};
    assign dv_ge  = (rem_sh >= {1'b0, r_dvs});
    assign rem_nx = dv_ge ? (rem_sh - {1'b0, r_dvs}) : rem_sh;

    bsfic_shift_mac u_mac (
        .i_clk (i_clk),
        .i_cmd (mac_cmd),
        .o_acc (w_acc)
    );

    always_comb begin
        logic [ERR_W-1:0]  ev;
        logic [ERR_W:0]    esum;
        logic [15:0]       vmag;
        logic [40:0]       inc;
        logic [48:0]       isum;
        logic [55:0]       t;
        logic [56:0]       u;
        logic              big;
        logic [49:0]       rat;
        logic              nneg;
        logic [49:0]       nabs;
        logic [31:0]       kmag;
        logic              ovf;
        logic [47:0]       mag;

        ev   = {in_ref[15], in_ref} - {in_vo[15], in_vo};
        esum = {ev[ERR_W-1], ev} + {r_prev[ERR_W-1], r_prev};
        vmag = in_vdc[15] ? (16'd0 - in_vdc) : in_vdc;
        inc  = w_acc[49:9];
        isum = {r_ei[47], r_ei} + {{8{inc[40]}}, inc};
        t    = w_acc[79:24];
        u    = 57'd0 - {t[55], t};
        big  = !u[56] && (u[55:0] > 56'd16777216);
        rat  = r_nsg ? (50'd0 - {10'd0, r_dvd[39:0]}) : {10'd0, r_dvd[39:0]};
        nneg = r_num[49];
        nabs = nneg ? (50'd0 - r_num) : r_num;
        kmag = r_ge[31] ? (32'd0 - r_ge) : r_ge;
        ovf  = ({7'd0, nabs[47:0]} >= {kmag, 23'd0});
        mag  = {1'b0, r_dvd};

        n_state    = r_state;
        n_cnt      = r_cnt;
        n_ei       = r_ei;
        n_prev     = r_prev;
        n_ev       = r_ev;
        n_cur      = r_cur;
        n_vlt      = r_vlt;
        n_nsg      = r_nsg;
        n_neg      = r_neg;
        n_rem      = r_rem;
        n_dvd      = r_dvd;
        n_dvs      = r_dvs;
        n_num      = r_num;
        n_res_duty = r_res_duty;
        n_res_clp  = r_res_clp;
        n_res_flt  = r_res_flt;
        mac_cmd    = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_res_duty = '0;
                    n_res_clp  = 1'b0;
                    n_res_flt  = 1'b0;
                    n_cnt      = '0;
                    n_state    = ST_WB;
                    case (in_req)
                        REQ_RUN: begin
                            n_ev         = ev;
                            n_cur        = in_cur;
                            n_vlt        = in_vo;
                            mac_cmd.load = 1'b1;
                            mac_cmd.clr  = 1'b1;
                            mac_cmd.mpr  = r_sp;
                            mac_cmd.mcd  = {{(ACC_W-ERR_W-1){esum[ERR_W]}}, esum};
                            n_state      = ST_R_INC;
                        end
                        REQ_PRESET: begin
                            n_prev = '0;
                            if (in_vin == 15'd0 || r_ge == 32'd0) begin
                                n_ei      = '0;
                                n_res_flt = 1'b1;
                            end else begin
                                n_cur   = in_cur;
                                n_vlt   = in_vdc;
                                n_nsg   = in_vdc[15];
                                n_rem   = '0;
                                n_dvd   = {7'd0, vmag, 24'd0};
                                n_dvs   = {17'd0, in_vin};
                                n_state = ST_P_RAT;
                            end
                        end
                        REQ_CLEAR: begin
                            n_ei   = '0;
                            n_prev = '0;
                        end
                        default: begin
                            // unused code leaves the state alone
                            n_state = ST_WB;
                        end
                    endcase
                end
            end
            ST_R_INC: begin
                mac_cmd.step = 1'b1;
                n_cnt        = r_cnt + 1'b1;
                if (r_cnt == MUL_LAST) begin
                    n_state = ST_R_ACC;
                end
            end
            ST_R_ACC: begin
                if (isum[48] != isum[47]) begin
                    n_ei = isum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
                end else begin
                    n_ei = isum[47:0];
                end
                n_prev       = r_ev;
                mac_cmd.load = 1'b1;
                mac_cmd.clr  = 1'b1;
                mac_cmd.mpr  = r_gi;
                mac_cmd.mcd  = {{40{r_cur[15]}}, r_cur, 24'd0};
                n_cnt        = '0;
                n_state      = ST_R_KI;
            end
            ST_R_KI, ST_R_KV, ST_R_KE, ST_P_KI, ST_P_KV: begin
                mac_cmd.step     = 1'b1;
                mac_cmd.neg_last = (r_cnt == MUL_LAST);
                n_cnt            = r_cnt + 1'b1;
                if (r_cnt == MUL_LAST) begin
                    n_cnt = '0;
                    case (r_state)
                        ST_R_KI: begin
                            mac_cmd.load = 1'b1;
                            mac_cmd.mpr  = r_gv;
                            mac_cmd.mcd  = {{40{r_vlt[15]}}, r_vlt, 24'd0};
                            n_state      = ST_R_KV;
                        end
                        ST_R_KV: begin
                            mac_cmd.load = 1'b1;
                            mac_cmd.mpr  = r_ge;
                            mac_cmd.mcd  = {{(ACC_W-INTEG_W){r_ei[47]}}, r_ei};
                            n_state      = ST_R_KE;
                        end
                        ST_P_KI: begin
                            mac_cmd.load = 1'b1;
                            mac_cmd.mpr  = r_gv;
                            mac_cmd.mcd  = {{64{r_vlt[15]}}, r_vlt};
                            n_state      = ST_P_KV;
                        end
                        ST_P_KV: begin
                            n_state = ST_P_NUM;
                        end
                        default: begin
                            n_state = ST_R_FIN;
                        end
                    endcase
                end
            end
            ST_R_FIN: begin
                if (big) begin
                    n_res_duty = 17'h10000;
                    n_res_clp  = 1'b1;
                end else if (u[56]) begin
                    n_res_duty = '0;
                    n_res_clp  = 1'b1;
                end else begin
                    n_res_duty = u[24:8];
                    n_res_clp  = 1'b0;
                end
                n_res_flt = 1'b0;
                n_state   = ST_WB;
            end
            ST_P_RAT, ST_P_DIV: begin
                n_rem = rem_nx;
                n_dvd = {r_dvd[45:0], dv_ge};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_cnt = '0;
                    if (r_state == ST_P_RAT) begin
                        mac_cmd.load = 1'b1;
                        mac_cmd.clr  = 1'b1;
                        mac_cmd.mpr  = r_gi;
                        mac_cmd.mcd  = {{64{r_cur[15]}}, r_cur};
                        n_state      = ST_P_KI;
                    end else begin
                        n_state = ST_P_FIN;
                    end
                end
            end
            ST_P_NUM: begin
                n_num   = (50'd0 - w_acc[49:0]) - rat;
                n_state = ST_P_CHK;
            end
            ST_P_CHK: begin
                n_neg = nneg ^ r_ge[31];
                if (ovf) begin
                    // quotient beyond the integrator range
                    n_ei    = (nneg ^ r_ge[31]) ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
                    n_state = ST_WB;
                end else begin
                    n_rem   = {8'd0, nabs[47:23]};
                    n_dvd   = {nabs[22:0], 24'd0};
                    n_dvs   = kmag;
                    n_cnt   = '0;
                    n_state = ST_P_DIV;
                end
            end
            ST_P_FIN: begin
                n_ei    = r_neg ? (48'd0 - mag) : mag;
                n_state = ST_WB;
            end
            ST_WB: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_ei      <= '0;
            r_prev    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ei    <= n_ei;
            r_prev  <= n_prev;
            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ev       <= n_ev;
        r_cur      <= n_cur;
        r_vlt      <= n_vlt;
        r_nsg      <= n_nsg;
        r_neg      <= n_neg;
        r_rem      <= n_rem;
        r_dvd      <= n_dvd;
        r_dvs      <= n_dvs;
        r_num      <= n_num;
        r_res_duty <= n_res_duty;
        r_res_clp  <= n_res_clp;
        r_res_flt  <= n_res_flt;
        if (out_load) begin
            r_m_duty <= r_res_duty;
            r_m_clp  <= r_res_clp;
            r_m_flt  <= r_res_flt;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {7'd0, r_m_duty};
    assign o_m_tuser  = {r_m_flt, r_m_clp};

    // configuration registers
    assign cfg_wr   = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gi <= GAIN_CUR_RST;
            r_gv <= GAIN_VLT_RST;
            r_ge <= GAIN_INT_RST;
            r_sp <= PERIOD_RST;
        end else if (cfg_wr) begin
            unique case (i_paddr[3:2])
                REG_GAIN_CUR: r_gi <= i_pwdata;
                REG_GAIN_VLT: r_gv <= i_pwdata;
                REG_GAIN_INT: r_ge <= i_pwdata;
                REG_PERIOD:   r_sp <= i_pwdata;
                default:      r_sp <= r_sp;
            endcase
        end
    end

    always_comb begin
        unique case (i_paddr[3:2])
            REG_GAIN_CUR: o_prdata = r_gi;
            REG_GAIN_VLT: o_prdata = r_gv;
            REG_GAIN_INT: o_prdata = r_ge;
            REG_PERIOD:   o_prdata = r_sp;
            default:      o_prdata = '0;
        endcase
    end

endmodule

>>> bench/tb_top.sv
// testbench for the buck state feedback integral controller core
// depends on bsfic_pkg and the core; self-checking against an in-bench predictor
`timescale 1ns / 1ps

module tb_top;
    import bsfic_pkg::*;

    typedef struct {
        logic [16:0] duty;
        logic        clamped;
        logic        fault;
    } t_duty_res;

    localparam longint INTEG_MAX = 64'sd140737488355327;
    localparam longint INTEG_MIN = -64'sd140737488355328;
    localparam longint ONE_Q24   = 64'sd16777216;
    localparam int     LIMIT_CYCLES = 2000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [79:0] i_s_tdata;
    logic [1:0]  i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [23:0] o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        i_psel;
    logic        i_penable;
    logic        i_pwrite;
    logic [3:0]  i_paddr;
    logic [31:0] i_pwdata;
    logic [31:0] o_prdata;
    logic        o_pready;

    buck_state_feedback_integral_controller_core i_dut (.*);

    // predictor state and configuration copy
    logic [31:0] k_cur, k_vlt, k_int, t_samp;
    longint      integ;
    longint      prev_err;
    t_duty_res   duty_q[$];
    int          n_err;
    int          cycles;
    int          hold_off;
    bit          rx_calm;
    bit          tx_calm;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic longint floor_shr(longint x, int k);
        return x >>> k;
    endfunction

    function automatic longint clip48(longint x);
        if (x > INTEG_MAX) return INTEG_MAX;
        if (x < INTEG_MIN) return INTEG_MIN;
        return x;
    endfunction

    function automatic t_duty_res predict_duty(logic [1:0] kind, logic [79:0] d);
        t_duty_res r;
        longint il, vo, vr, vdc, vin, ki, kv, kev, ev, eh, el, u, ratio, num;
        longint unsigned nmag, kmag, q1, rm, mag;
        bit neg;
        il  = longint'($signed(d[15:0]));
        vo  = longint'($signed(d[31:16]));
        vr  = longint'($signed(d[47:32]));
        vdc = longint'($signed(d[63:48]));
        vin = longint'(d[78:64]);
        ki  = longint'($signed(k_cur));
        kv  = longint'($signed(k_vlt));
        kev = longint'($signed(k_int));
        r = '{17'd0, 1'b0, 1'b0};
        case (kind)
            REQ_RUN: begin
                ev = vr - vo;
                integ = clip48(integ + floor_shr(longint'(t_samp) * (ev + prev_err), 9));
                prev_err = ev;
                eh = floor_shr(integ, 24);
                el = integ - eh * ONE_Q24;
                u = -(ki * il) - (kv * vo) - (kev * eh + floor_shr(kev * el, 24));
                if (u > ONE_Q24) begin
                    r.duty = 17'd65536;
                    r.clamped = 1'b1;
                end else if (u < 0) begin
                    r.clamped = 1'b1;
                end else begin
                    r.duty = 17'(u >>> 8);
                end
            end
            REQ_PRESET: begin
                prev_err = 0;
                if (vin == 0 || kev == 0) begin
                    integ = 0;
                    r.fault = 1'b1;
                end else begin
                    ratio = (vdc * ONE_Q24) / vin;
                    num = -(ki * il) - (kv * vdc) - ratio;
                    neg = (num < 0) != (kev < 0);
                    nmag = (num < 0) ? longint'(0) - num : num;
                    kmag = (kev < 0) ? longint'(0) - kev : kev;
                    q1 = nmag / kmag;
                    rm = nmag % kmag;
                    if (q1 >= (64'd1 << 23)) mag = 64'd1 << 47;
                    else mag = (q1 << 24) + ((rm << 24) / kmag);
                    if (neg) begin
                        if (mag > (64'd1 << 47)) mag = 64'd1 << 47;
                        integ = -longint'(mag);
                    end else begin
                        if (mag > INTEG_MAX) mag = INTEG_MAX;
                        integ = longint'(mag);
                    end
                end
            end
            REQ_CLEAR: begin
                integ = 0;
                prev_err = 0;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        n_err++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_duty_res w;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (duty_q.size() == 0) begin
                report_mismatch("unexpected result", o_m_tdata[16:0], -1);
            end else begin
                w = duty_q.pop_front();
                if (o_m_tdata[16:0] !== w.duty) report_mismatch("duty", o_m_tdata[16:0], w.duty);
                if (o_m_tuser[0] !== w.clamped)
                    report_mismatch("clamped", o_m_tuser[0], w.clamped);
                if (o_m_tuser[1] !== w.fault) report_mismatch("fault", o_m_tuser[1], w.fault);
            end
        end
    end

    // receiver idling and long hold-off
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= rx_calm ? 1'b1 : ($urandom_range(99) >= 25);
        end
    end

    // tvalid stays high after the handshake; a gap or drain() lowers it
    task automatic send_req(logic [1:0] kind, logic [79:0] d);
        if (!tx_calm) begin
            while ($urandom_range(99) < 25) begin
                i_s_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        duty_q.push_back(predict_duty(kind, d));
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= d;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    function automatic logic [79:0] pack_req(logic [15:0] il, logic [15:0] vo,
                                            logic [15:0] vr, logic [15:0] vdc,
                                            logic [14:0] vin);
        return {1'b0, vin, vdc, vr, vo, il};
    endfunction

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (duty_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        i_psel <= 1'b1;
        i_pwrite <= 1'b1;
        i_paddr <= {idx, 2'b00};
        i_pwdata <= val;
        @(posedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk);
        i_psel <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite <= 1'b0;
        case (idx)
            REG_GAIN_CUR: k_cur = val;
            REG_GAIN_VLT: k_vlt = val;
            REG_GAIN_INT: k_int = val;
            default:      t_samp = val;
        endcase
    endtask

    function automatic logic [15:0] rnd_meas();
        case ($urandom_range(4))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($urandom_range(3000)) - 16'd1500;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [14:0] rnd_vin();
        case ($urandom_range(5))
            0: return 15'd0;
            1: return 15'h7FFF;
            default: return 15'($urandom_range(32767, 1));
        endcase
    endfunction

    function automatic logic [31:0] rnd_gain();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'd0;
            3: return 32'($urandom_range(400000)) - 32'd200000;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        send_req(REQ_RUN, pack_req(16'd0, 16'd0, 16'd0, 16'd0, 15'd0));
        send_req(REQ_RUN, pack_req(16'h7FFF, 16'h8000, 16'h7FFF, 16'd0, 15'd0));
        send_req(REQ_RUN, pack_req(16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, 15'h7FFF));
        send_req(REQ_RUN, pack_req(16'd256, 16'd1280, 16'd1280, 16'd0, 15'd0));
        send_req(REQ_PRESET, pack_req(16'd256, 16'd0, 16'd0, 16'd1280, 15'd3072));
        send_req(REQ_RUN, pack_req(16'd256, 16'd1270, 16'd1280, 16'd0, 15'd0));
        send_req(REQ_PRESET, pack_req(16'd100, 16'd0, 16'd0, 16'd500, 15'd0));
        send_req(REQ_PRESET, pack_req(16'h7FFF, 16'hFFFF, 16'hFFFF, 16'h8000, 15'd1));
        send_req(REQ_PRESET, pack_req(16'h8000, 16'd0, 16'd0, 16'h7FFF, 15'h7FFF));
        send_req(REQ_CLEAR, pack_req(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h7FFF));
        send_req(2'd3, pack_req(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 15'h1111));
        send_req(REQ_RUN, pack_req(16'd0, 16'd1000, 16'd1100, 16'd0, 15'd0));
        drain();
        write_reg(REG_GAIN_INT, 32'd0);
        send_req(REQ_PRESET, pack_req(16'd10, 16'd0, 16'd0, 16'd500, 15'd1000));
        send_req(REQ_RUN, pack_req(16'd10, 16'd900, 16'd1000, 16'd0, 15'd0));
        drain();
        write_reg(REG_GAIN_INT, GAIN_INT_RST);
    endtask

    task automatic test_random_phase(int n);
        logic [15:0] il, vr;
        for (int i = 0; i < n; i++) begin
            il = rnd_meas();
            vr = rnd_meas();
            case ($urandom_range(19))
                0:       send_req(REQ_PRESET, pack_req(il, rnd_meas(), vr, rnd_meas(), rnd_vin()));
                1:       send_req(REQ_CLEAR, pack_req(il, rnd_meas(), vr, rnd_meas(), rnd_vin()));
                2:       send_req(2'd3, pack_req(il, rnd_meas(), vr, rnd_meas(), rnd_vin()));
                default: send_req(REQ_RUN, pack_req(il, rnd_meas(), vr, rnd_meas(), rnd_vin()));
            endcase
        end
    endtask

    task automatic test_config_sweep();
        for (int p = 0; p < 8; p++) begin
            drain();
            if (p == 0) begin
                write_reg(REG_GAIN_CUR, 32'h7FFF_FFFF);
                write_reg(REG_GAIN_VLT, 32'h8000_0000);
                write_reg(REG_GAIN_INT, 32'h7FFF_FFFF);
                write_reg(REG_PERIOD, 32'hFFFF_FFFF);
            end else if (p == 1) begin
                write_reg(REG_GAIN_CUR, 32'h8000_0000);
                write_reg(REG_GAIN_VLT, 32'h7FFF_FFFF);
                write_reg(REG_GAIN_INT, 32'h8000_0000);
                write_reg(REG_PERIOD, 32'd0);
            end else if (p == 2) begin
                write_reg(REG_GAIN_CUR, GAIN_CUR_RST);
                write_reg(REG_GAIN_VLT, GAIN_VLT_RST);
                write_reg(REG_GAIN_INT, GAIN_INT_RST);
                write_reg(REG_PERIOD, PERIOD_RST);
            end else begin
                write_reg(REG_GAIN_CUR, rnd_gain());
                write_reg(REG_GAIN_VLT, rnd_gain());
                write_reg(REG_GAIN_INT, rnd_gain());
                write_reg(REG_PERIOD, ($urandom_range(1)) ? $urandom : 32'($urandom_range(200000)));
            end
            test_random_phase(140);
        end
    endtask

    // receiver stalls long while sender keeps offering
    task automatic test_backpressure();
        hold_off = 2000;
        test_random_phase(20);
        drain();
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        test_random_phase(60);
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        drain();
    endtask

    initial begin
        n_err = 0;
        cycles = 0;
        hold_off = 0;
        rx_calm = 1'b0;
        tx_calm = 1'b0;
        integ = 0;
        prev_err = 0;
        k_cur = GAIN_CUR_RST;
        k_vlt = GAIN_VLT_RST;
        k_int = GAIN_INT_RST;
        t_samp = PERIOD_RST;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = '0;
        i_m_tready = 1'b0;
        i_psel = 1'b0;
        i_penable = 1'b0;
        i_pwrite = 1'b0;
        i_paddr = '0;
        i_pwdata = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_phase(60);
        test_backpressure();
        test_config_sweep();
        drain();
        if (n_err == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
